// File: hw/rtl/itwm_pkg.sv
package itwm_pkg;

    localparam int WINDOW_LEN  = 30;
    localparam int SAMPLE_BITS = 24;

    // Ranks, strides and counts all fit in five bits for a window of up to 30.
    localparam int IDX_W   = 5;
    localparam int CNT_W   = 5;
    localparam int CFG_W   = 5;
    localparam int CFG_IDX_W = 2;
    localparam int SUM_W   = SAMPLE_BITS + CNT_W;
    localparam int FEN_W   = SAMPLE_BITS + 3;
    localparam int DIV_CNT_W = $clog2(SUM_W + 1);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW_LEN - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(WINDOW_LEN);

    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER  = 2'd2;

    localparam logic [CFG_W-1:0] STRIDE_RST = 5'd5;
    localparam logic [CFG_W-1:0] LOWER_RST  = 5'd6;
    localparam logic [CFG_W-1:0] UPPER_RST  = 5'd22;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_CMP,
        S_SEL,
        S_FEN_IQR,
        S_FEN_MARGIN,
        S_FEN_BOUNDS,
        S_SUM,
        S_DIV_START,
        S_DIV,
        S_HOLD
    } state_t;

    typedef struct packed {
        logic shift_in;
        logic rotate;
        logic load;
        logic cmp;
    } cell_ctrl_t;

endpackage

// File: hw/rtl/itwm_cell.sv
module itwm_cell (
    input  logic                                      clk,
    input  itwm_pkg::cell_ctrl_t                      ctrl,
    input  logic signed [itwm_pkg::SAMPLE_BITS-1:0]   s_prev,
    input  logic signed [itwm_pkg::SAMPLE_BITS-1:0]   c_prev,
    input  logic [itwm_pkg::CNT_W-1:0]                lt_prev,
    input  logic [itwm_pkg::CNT_W-1:0]                le_prev,
    output logic signed [itwm_pkg::SAMPLE_BITS-1:0]   s,
    output logic signed [itwm_pkg::SAMPLE_BITS-1:0]   c,
    output logic [itwm_pkg::CNT_W-1:0]                lt,
    output logic [itwm_pkg::CNT_W-1:0]                le
);

    localparam int CNT_W = itwm_pkg::CNT_W;

    logic signed [itwm_pkg::SAMPLE_BITS-1:0] s_reg;
    logic signed [itwm_pkg::SAMPLE_BITS-1:0] c_reg;
    logic [itwm_pkg::CNT_W-1:0]              lt_reg;
    logic [itwm_pkg::CNT_W-1:0]              le_reg;

    // Held sample moves on a new item or a rotation; the probe value
    // circulates past every held sample while counting ranks.
    always_ff @(posedge clk)
    begin
        if (ctrl.shift_in || ctrl.rotate)
        begin
            s_reg <= s_prev;
        end
        if (ctrl.load)
        begin
            c_reg  <= s_reg;
            lt_reg <= '0;
            le_reg <= '0;
        end
        else if (ctrl.cmp)
        begin
            c_reg  <= c_prev;
            lt_reg <= lt_reg + CNT_W'(c_reg < s_reg);
            le_reg <= le_reg + CNT_W'(c_reg <= s_reg);
        end
        else if (ctrl.rotate)
        begin
            lt_reg <= lt_prev;
            le_reg <= le_prev;
        end
    end

    assign s  = s_reg;
    assign c  = c_reg;
    assign lt = lt_reg;
    assign le = le_reg;

endmodule

// File: hw/rtl/itwm_div.sv
module itwm_div (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      start,
    input  logic signed [itwm_pkg::SUM_W-1:0]         dividend,
    input  logic [itwm_pkg::CNT_W-1:0]                divisor,
    output logic                                      done,
    output logic signed [itwm_pkg::SAMPLE_BITS-1:0]   quotient
);

    logic [itwm_pkg::SUM_W-1:0]     quo_reg;
    logic [itwm_pkg::CNT_W-1:0]     rem_reg;
    logic [itwm_pkg::CNT_W-1:0]     dsr_reg;
    logic                           neg_reg;
    logic [itwm_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                           busy_reg;
    logic                           done_reg;
    logic [itwm_pkg::CNT_W:0]       rem_sh;
    logic                           fits;
    logic [itwm_pkg::SUM_W-1:0]     mag;
    logic [itwm_pkg::SUM_W-1:0]     signed_quo;

    assign mag    = dividend[itwm_pkg::SUM_W-1] ? (~dividend + 1'b1) : dividend;
    assign rem_sh = {rem_reg, quo_reg[itwm_pkg::SUM_W-1]};
    assign fits   = rem_sh >= {1'b0, dsr_reg};

    // One quotient bit per cycle, restoring.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == itwm_pkg::DIV_CNT_W'(itwm_pkg::SUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= mag;
            rem_reg <= '0;
            dsr_reg <= divisor;
            neg_reg <= dividend[itwm_pkg::SUM_W-1];
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[itwm_pkg::SUM_W-2:0], fits};
            rem_reg <= fits ? itwm_pkg::CNT_W'(rem_sh - {1'b0, dsr_reg})
                            : rem_sh[itwm_pkg::CNT_W-1:0];
        end
    end

    assign signed_quo = neg_reg ? (~quo_reg + 1'b1) : quo_reg;
    assign quotient   = signed_quo[itwm_pkg::SAMPLE_BITS-1:0];
    assign done       = done_reg;

endmodule

// File: hw/rtl/iqr_trimmed_window_mean.sv
// Channel  | valid     | stall     | payload
// ---------+-----------+-----------+---------------------------
// input    | in_valid  | in_stall  | sample
// output   | out_valid | out_stall | trimmed_mean, kept_count
//
// A sample that is not a stride boundary, or arrives before the window fills,
// leaves the block idle and ready for the next sample. A result takes three
// passes around the cell chain (rank count, quartile pick, fence sum) and the
// serial divider, one quotient bit per cycle.
// Reset clears all control state; the chain needs no clearing.
// in_stall is high while a result is computed or waits for the output slot.
module iqr_trimmed_window_mean (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic signed [itwm_pkg::SAMPLE_BITS-1:0] sample,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic signed [itwm_pkg::SAMPLE_BITS-1:0] trimmed_mean,
    output logic [itwm_pkg::CNT_W-1:0]              kept_count,
    input  logic                                    cfg_we,
    input  logic [itwm_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [itwm_pkg::CFG_W-1:0]              cfg_data
);

    localparam int N  = itwm_pkg::WINDOW_LEN;
    localparam int B  = itwm_pkg::SAMPLE_BITS;
    localparam int CW = itwm_pkg::CNT_W;
    localparam int FW = itwm_pkg::FEN_W;
    localparam int SW = itwm_pkg::SUM_W;

    itwm_pkg::state_t     state_reg, state_next;
    itwm_pkg::cell_ctrl_t ctrl;

    logic [itwm_pkg::CFG_W-1:0] stride_reg, lower_reg, upper_reg;
    logic [CW-1:0]              scnt_reg, scnt_next;
    logic [CW-1:0]              fill_reg;
    logic [itwm_pkg::IDX_W-1:0] step_reg;
    logic                       step_last;

    logic signed [B-1:0]  s_w  [N];
    logic signed [B-1:0]  c_w  [N];
    logic [CW-1:0]        lt_w [N];
    logic [CW-1:0]        le_w [N];

    logic signed [B-1:0]  q1_reg, q3_reg;
    logic signed [FW-1:0] iqr_reg, margin_reg, low_reg, high_reg;
    logic signed [SW-1:0] sum_reg;
    logic [CW-1:0]        kept_reg;

    logic                 out_valid_reg;
    logic signed [B-1:0]  mean_reg;
    logic [CW-1:0]        kcnt_reg;

    logic                 in_acc;
    logic                 boundary;
    logic                 filled_now;
    logic [CW-1:0]        stride_eff;
    logic [CW-1:0]        rank_lo, rank_hi;
    logic                 lo_hit, hi_hit;
    logic signed [FW-1:0] head_wide;
    logic                 in_fence;
    logic                 div_start, div_done;
    logic signed [B-1:0]  div_quo;
    logic                 slot_free;

    assign in_acc     = in_valid && !in_stall;
    assign stride_eff = (stride_reg == '0) ? CW'(1) : stride_reg;
    assign scnt_next  = scnt_reg + 1'b1;
    assign boundary   = (scnt_next >= stride_eff) || (scnt_next == '0);
    assign filled_now = (fill_reg + 1'b1) >= itwm_pkg::FULL_CNT;
    assign rank_lo    = (lower_reg >= itwm_pkg::FULL_CNT) ? itwm_pkg::LAST_IDX : lower_reg;
    assign rank_hi    = (upper_reg >= itwm_pkg::FULL_CNT) ? itwm_pkg::LAST_IDX : upper_reg;
    assign lo_hit     = (lt_w[N-1] <= rank_lo) && (rank_lo < le_w[N-1]);
    assign hi_hit     = (lt_w[N-1] <= rank_hi) && (rank_hi < le_w[N-1]);
    assign head_wide  = FW'(s_w[N-1]);
    assign in_fence   = (head_wide >= low_reg) && (head_wide <= high_reg);
    assign step_last  = step_reg == itwm_pkg::LAST_IDX;
    assign slot_free  = !out_valid_reg || !out_stall;

    for (genvar i = 0; i < N; i++)
    begin : g_cell
        itwm_cell u_cell (
            .clk     (clk),
            .ctrl    (ctrl),
            .s_prev  ((i == 0) ? (ctrl.rotate ? s_w[N-1] : sample) : s_w[(i+N-1)%N]),
            .c_prev  (c_w[(i+N-1)%N]),
            .lt_prev (lt_w[(i+N-1)%N]),
            .le_prev (le_w[(i+N-1)%N]),
            .s       (s_w[i]),
            .c       (c_w[i]),
            .lt      (lt_w[i]),
            .le      (le_w[i])
        );
    end

    itwm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (kept_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb
    begin
        state_next    = state_reg;
        ctrl          = '0;
        div_start     = 1'b0;
        in_stall      = 1'b1;
        unique case (state_reg)
            itwm_pkg::S_IDLE:
            begin
                in_stall      = 1'b0;
                ctrl.shift_in = in_acc;
                if (in_acc && boundary && filled_now)
                begin
                    state_next = itwm_pkg::S_LOAD;
                end
            end
            itwm_pkg::S_LOAD:
            begin
                ctrl.load  = 1'b1;
                state_next = itwm_pkg::S_CMP;
            end
            itwm_pkg::S_CMP:
            begin
                ctrl.cmp = 1'b1;
                if (step_last)
                begin
                    state_next = itwm_pkg::S_SEL;
                end
            end
            itwm_pkg::S_SEL:
            begin
                ctrl.rotate = 1'b1;
                if (step_last)
                begin
                    state_next = itwm_pkg::S_FEN_IQR;
                end
            end
            itwm_pkg::S_FEN_IQR:    state_next = itwm_pkg::S_FEN_MARGIN;
            itwm_pkg::S_FEN_MARGIN: state_next = itwm_pkg::S_FEN_BOUNDS;
            itwm_pkg::S_FEN_BOUNDS: state_next = itwm_pkg::S_SUM;
            itwm_pkg::S_SUM:
            begin
                ctrl.rotate = 1'b1;
                if (step_last)
                begin
                    state_next = itwm_pkg::S_DIV_START;
                end
            end
            itwm_pkg::S_DIV_START:
            begin
                // Drop the result when nothing lies inside the fences.
                if (kept_reg == '0)
                begin
                    state_next = itwm_pkg::S_IDLE;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = itwm_pkg::S_DIV;
                end
            end
            itwm_pkg::S_DIV:
            begin
                if (div_done)
                begin
                    state_next = itwm_pkg::S_HOLD;
                end
            end
            itwm_pkg::S_HOLD:
            begin
                if (slot_free)
                begin
                    state_next = itwm_pkg::S_IDLE;
                end
            end
            default: state_next = itwm_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= itwm_pkg::S_IDLE;
            stride_reg    <= itwm_pkg::STRIDE_RST;
            lower_reg     <= itwm_pkg::LOWER_RST;
            upper_reg     <= itwm_pkg::UPPER_RST;
            scnt_reg      <= '0;
            fill_reg      <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    itwm_pkg::CFG_STRIDE: stride_reg <= cfg_data;
                    itwm_pkg::CFG_LOWER:  lower_reg  <= cfg_data;
                    itwm_pkg::CFG_UPPER:  upper_reg  <= cfg_data;
                    default: ;
                endcase
            end
            if (in_acc)
            begin
                scnt_reg <= boundary ? '0 : scnt_next;
                if (!filled_now)
                begin
                    fill_reg <= fill_reg + 1'b1;
                end
                else
                begin
                    fill_reg <= itwm_pkg::FULL_CNT;
                end
            end
            if (ctrl.cmp || ctrl.rotate)
            begin
                step_reg <= step_last ? '0 : step_reg + 1'b1;
            end
            else
            begin
                step_reg <= '0;
            end
            if (state_reg == itwm_pkg::S_HOLD && slot_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == itwm_pkg::S_SEL)
        begin
            if (lo_hit)
            begin
                q1_reg <= s_w[N-1];
            end
            if (hi_hit)
            begin
                q3_reg <= s_w[N-1];
            end
        end
        if (state_reg == itwm_pkg::S_FEN_IQR)
        begin
            iqr_reg <= FW'(q3_reg) - FW'(q1_reg);
        end
        if (state_reg == itwm_pkg::S_FEN_MARGIN)
        begin
            margin_reg <= iqr_reg + (iqr_reg >>> 1);
        end
        if (state_reg == itwm_pkg::S_FEN_BOUNDS)
        begin
            low_reg  <= FW'(q1_reg) - margin_reg;
            high_reg <= FW'(q3_reg) + margin_reg;
            sum_reg  <= '0;
            kept_reg <= '0;
        end
        if (state_reg == itwm_pkg::S_SUM && in_fence)
        begin
            sum_reg  <= sum_reg + SW'(s_w[N-1]);
            kept_reg <= kept_reg + 1'b1;
        end
        if (state_reg == itwm_pkg::S_HOLD && slot_free)
        begin
            mean_reg <= div_quo;
            kcnt_reg <= kept_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign trimmed_mean = mean_reg;
    assign kept_count   = kcnt_reg;

endmodule
